// ===== rtl/cau_pkg.sv =====
`default_nettype none
package cau_pkg;

  // Fraction bits of the Q format on all operands and results
  localparam int FRAC_BITS = 16;
  // Quotient bits resolved by the chain; larger quotients always saturate
  localparam int QW = 33;
  // One cell per quotient bit; the same count covers the 33 root steps
  localparam int NCELL = QW;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_DIV   = 3'd2,
    OP_MAG1  = 3'd3,
    OP_MAG2  = 3'd4,
    OP_CONJ1 = 3'd5,
    OP_CONJ2 = 3'd6
  } op_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
  } res_t;

  // Payload that walks down the chain of cells
  typedef struct packed {
    op_t           op;
    res_t          early;    // result of add, conj and multiply
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [63:0]   den;      // divisor, or the sum of squares for a magnitude
    logic [63:0]   rem_re;
    logic [63:0]   rem_im;
    logic [QW-1:0] nlo_re;   // dividend bits still to bring down
    logic [QW-1:0] nlo_im;
    logic [QW-1:0] quo_re;
    logic [QW-1:0] quo_im;
    logic [63:0]   sq_v;     // root remainder
    logic [64:0]   sq_bit;
    logic [65:0]   sq_res;
  } cell_t;

  // Saturate a sign and magnitude to 32 bits; returns {overflow, value}
  function automatic logic [32:0] sat32(input logic neg, input logic [63:0] m);
    logic [32:0] r;
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[31:0]};
    end else begin
      if (m > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, ~m[31:0] + 32'd1};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
`default_nettype none
module cau_front
  import cau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] first_real,
  input  wire logic signed [31:0] first_imag,
  input  wire logic signed [31:0] second_real,
  input  wire logic signed [31:0] second_imag,
  output logic                    dn_valid,
  output cell_t                   dn_item
);

  function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] s;
    logic [32:0] r;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    else r = {1'b0, s[31:0]};
    return r;
  endfunction

  function automatic logic [32:0] sat_neg(input logic signed [31:0] a);
    logic [32:0] r;
    if (a == 32'sh8000_0000) r = {1'b1, 32'h7FFF_FFFF};
    else r = {1'b0, 32'(-a)};
    return r;
  endfunction

  // Stage A: products, squares and the simple results
  logic               a_valid, b_valid, c_valid;
  op_t                a_op, b_op, c_op;
  res_t               a_early, b_early, c_early;
  logic signed [63:0] a_p_rr, a_p_ii, a_p_ri, a_p_ir, a_sq_x, a_sq_y;
  logic signed [31:0] sel_re, sel_im;
  res_t               early_a;
  logic [32:0]        t_re, t_im;

  always_comb begin
    sel_re  = (op_t'(op) == OP_MAG1) ? first_real : second_real;
    sel_im  = (op_t'(op) == OP_MAG1) ? first_imag : second_imag;
    early_a = '0;
    t_re    = '0;
    t_im    = '0;
    case (op)
      OP_ADD: begin
        t_re = sat_add(first_real, second_real);
        t_im = sat_add(first_imag, second_imag);
        early_a = '{re: t_re[31:0], im: t_im[31:0], ovf: t_re[32] | t_im[32]};
      end
      OP_CONJ1: begin
        t_im = sat_neg(first_imag);
        early_a = '{re: first_real, im: t_im[31:0], ovf: t_im[32]};
      end
      OP_CONJ2: begin
        t_im = sat_neg(second_imag);
        early_a = '{re: second_real, im: t_im[31:0], ovf: t_im[32]};
      end
      default: early_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op    <= op_t'(op);
      a_early <= early_a;
      a_p_rr  <= first_real * second_real;
      a_p_ii  <= first_imag * second_imag;
      a_p_ri  <= first_real * second_imag;
      a_p_ir  <= first_imag * second_real;
      a_sq_x  <= sel_re * sel_re;
      a_sq_y  <= sel_im * sel_im;
    end
  end

  // Stage B: combine products into the product parts or the two numerators, and the divisor
  logic signed [64:0] b_v_re, b_v_im;
  logic [63:0]        b_den, c_den;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op    <= a_op;
      b_early <= a_early;
      b_v_re  <= (a_op == OP_MUL) ? 65'(a_p_rr) - 65'(a_p_ii) : 65'(a_p_rr) + 65'(a_p_ii);
      b_v_im  <= (a_op == OP_MUL) ? 65'(a_p_ri) + 65'(a_p_ir) : 65'(a_p_ir) - 65'(a_p_ri);
      b_den   <= 64'(a_sq_x) + 64'(a_sq_y);
    end
  end

  // Stage C: split into sign and magnitude
  logic        c_neg_re, c_neg_im;
  logic [63:0] c_m_re, c_m_im;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_op     <= b_op;
      c_early  <= b_early;
      c_den    <= b_den;
      c_neg_re <= b_v_re[64];
      c_neg_im <= b_v_im[64];
      c_m_re   <= b_v_re[64] ? 64'(-b_v_re) : 64'(b_v_re);
      c_m_im   <= b_v_im[64] ? 64'(-b_v_im) : 64'(b_v_im);
    end
  end

  // Stage D: round the product, seed the dividers and the root
  logic [63:0] rnd_re, rnd_im, shl_re, shl_im, hi_re, hi_im;
  logic [32:0] s_re, s_im;
  cell_t       seed;

  always_comb begin
    rnd_re = (c_m_re + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_im = (c_m_im + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    s_re   = sat32(c_neg_re && (rnd_re != 64'd0), rnd_re);
    s_im   = sat32(c_neg_im && (rnd_im != 64'd0), rnd_im);
    shl_re = c_m_re << FRAC_BITS;
    shl_im = c_m_im << FRAC_BITS;
    hi_re  = c_m_re >> (QW - FRAC_BITS);
    hi_im  = c_m_im >> (QW - FRAC_BITS);

    seed        = '0;
    seed.op     = c_op;
    seed.early  = c_early;
    if (c_op == OP_MUL) seed.early = '{re: s_re[31:0], im: s_im[31:0], ovf: s_re[32] | s_im[32]};
    seed.dz     = (c_den == 64'd0);
    seed.neg_re = c_neg_re;
    seed.neg_im = c_neg_im;
    seed.big_re = (hi_re >= c_den);
    seed.big_im = (hi_im >= c_den);
    seed.den    = c_den;
    seed.rem_re = hi_re;
    seed.rem_im = hi_im;
    seed.nlo_re = shl_re[QW-1:0];
    seed.nlo_im = shl_im[QW-1:0];
    seed.sq_v   = c_den;
    seed.sq_bit = 65'd1 << 64;
  end

  always_ff @(posedge clk) begin
    if (rst) dn_valid <= 1'b0;
    else if (en) dn_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (en) dn_item <= seed;
  end

endmodule
`default_nettype wire

// ===== rtl/cau_cell.sv =====
`default_nettype none
module cau_cell
  import cau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic up_valid,
  input  wire cell_t up_item,
  output logic      dn_valid,
  output cell_t     dn_item
);

  logic [64:0] sh_re, sh_im;
  logic        take_re, take_im;
  logic [65:0] trial;
  cell_t       nx;

  // One quotient bit for each divider and one root step
  always_comb begin
    nx      = up_item;
    sh_re   = {up_item.rem_re, up_item.nlo_re[QW-1]};
    sh_im   = {up_item.rem_im, up_item.nlo_im[QW-1]};
    take_re = sh_re >= {1'b0, up_item.den};
    take_im = sh_im >= {1'b0, up_item.den};
    nx.rem_re = take_re ? 64'(sh_re - {1'b0, up_item.den}) : sh_re[63:0];
    nx.rem_im = take_im ? 64'(sh_im - {1'b0, up_item.den}) : sh_im[63:0];
    nx.nlo_re = up_item.nlo_re << 1;
    nx.nlo_im = up_item.nlo_im << 1;
    nx.quo_re = {up_item.quo_re[QW-2:0], take_re};
    nx.quo_im = {up_item.quo_im[QW-2:0], take_im};

    trial = up_item.sq_res + 66'(up_item.sq_bit);
    if (66'(up_item.sq_v) >= trial) begin
      nx.sq_v   = up_item.sq_v - trial[63:0];
      nx.sq_res = (up_item.sq_res >> 1) + 66'(up_item.sq_bit);
    end else begin
      nx.sq_res = up_item.sq_res >> 1;
    end
    nx.sq_bit = up_item.sq_bit >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) dn_valid <= 1'b0;
    else if (en) dn_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (en) dn_item <= nx;
  end

endmodule
`default_nettype wire

// ===== rtl/cau_back.sv =====
`default_nettype none
module cau_back
  import cau_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   up_valid,
  input  wire cell_t  up_item,
  output logic        out_valid,
  output logic [31:0] result_real,
  output logic [31:0] result_imag,
  output logic        overflow,
  output logic        divide_by_zero
);

  logic [63:0] q_re, q_im, root;
  logic [32:0] s_re, s_im, s_mag;
  res_t        res;
  logic        dz;

  // Round the quotients and the root, then pick by operation
  always_comb begin
    q_re = 64'(up_item.quo_re) +
           64'(up_item.rem_re >= (up_item.den - up_item.rem_re));
    q_im = 64'(up_item.quo_im) +
           64'(up_item.rem_im >= (up_item.den - up_item.rem_im));
    if (up_item.big_re) q_re = 64'd1 << 40;
    if (up_item.big_im) q_im = 64'd1 << 40;
    s_re = sat32(up_item.neg_re && (q_re != 64'd0), q_re);
    s_im = sat32(up_item.neg_im && (q_im != 64'd0), q_im);

    root = up_item.sq_res[63:0] + 64'(66'(up_item.sq_v) > up_item.sq_res);
    s_mag = sat32(1'b0, root);

    res = up_item.early;
    dz  = 1'b0;
    unique case (up_item.op) inside
      OP_DIV: begin
        if (up_item.dz) begin
          res = '0;
          dz  = 1'b1;
        end else begin
          res = '{re: s_re[31:0], im: s_im[31:0], ovf: s_re[32] | s_im[32]};
        end
      end
      OP_MAG1, OP_MAG2: res = '{re: s_mag[31:0], im: 32'd0, ovf: s_mag[32]};
      default: res = up_item.early;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_real    <= res.re;
      result_imag    <= res.im;
      overflow       <= res.ovf;
      divide_by_zero <= dz;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
`default_nettype none
// Complex arithmetic unit on signed Q16.16 operands: sum, product, quotient,
// magnitude and conjugate, one result item per input item. The unit is a fixed
// pipeline of 38 stages (four front stages of products and sums, 33 divider and
// square-root cells that each resolve one quotient bit and one root step, and
// the output register), and one item is accepted every cycle while no finished
// result waits at a stalled output. A stall on the output freezes the whole
// pipeline and raises the input stall for as long as the finished result is not
// taken.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] first_real,
  input  wire logic signed [31:0] first_imag,
  input  wire logic signed [31:0] second_real,
  input  wire logic signed [31:0] second_imag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      result_real,
  output logic signed [31:0]      result_imag,
  output logic                    overflow,
  output logic                    divide_by_zero
);

  logic  en;
  logic  vchain [0:NCELL];
  cell_t ichain [0:NCELL];

  // Advance everything unless a finished item waits at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cau_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .op          (op),
    .first_real  (first_real),
    .first_imag  (first_imag),
    .second_real (second_real),
    .second_imag (second_imag),
    .dn_valid    (vchain[0]),
    .dn_item     (ichain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (vchain[i]),
      .up_item  (ichain[i]),
      .dn_valid (vchain[i+1]),
      .dn_item  (ichain[i+1])
    );
  end

  cau_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .up_valid       (vchain[NCELL]),
    .up_item        (ichain[NCELL]),
    .out_valid      (out_valid),
    .result_real    (result_real),
    .result_imag    (result_imag),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero)
  );

endmodule
`default_nettype wire

// ===== test/complex_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
module complex_arithmetic_unit_checker
  import cau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] first_real,
  input  wire logic signed [31:0] first_imag,
  input  wire logic signed [31:0] second_real,
  input  wire logic signed [31:0] second_imag,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] result_real,
  input  wire logic signed [31:0] result_imag,
  input  wire logic               overflow,
  input  wire logic               divide_by_zero,
  output int                      errors,
  output int                      waiting
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_res_t;

  cplx_res_t expected_results[$];

  // Clamp a sign and magnitude into 32 bits, flagging any clip
  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] m,
                                          inout logic ovf);
    if (!neg) begin
      if (m > 128'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 128'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return -m[31:0];
  endfunction

  function automatic logic [127:0] abs66(input logic signed [65:0] v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m;
  endfunction

  // Product part: round magnitude to nearest, ties away from zero
  function automatic logic [31:0] fix_round(input logic signed [65:0] v, inout logic ovf);
    logic [127:0] m;
    m = (abs66(v) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clamp32((v < 0) && (m != 0), m, ovf);
  endfunction

  function automatic logic [31:0] fix_div(input logic signed [65:0] n, input logic [127:0] d,
                                          inout logic ovf);
    logic [127:0] q;
    logic [127:0] r;
    q = (abs66(n) << FRAC_BITS) / d;
    r = (abs66(n) << FRAC_BITS) % d;
    if (r >= d - r) q = q + 1;
    return clamp32((n < 0) && (q != 0), q, ovf);
  endfunction

  // Square root of re^2+im^2, rounded to nearest
  function automatic logic [31:0] root_mag(input logic signed [65:0] a,
                                           input logic signed [65:0] b, inout logic ovf);
    logic [127:0] s;
    logic [127:0] root;
    logic [127:0] trial;
    s = 128'(a * a) + 128'(b * b);
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= s) root = trial;
    end
    if (s - root * root > root) root = root + 1;
    return clamp32(1'b0, root, ovf);
  endfunction

  function automatic cplx_res_t compute_result(input logic [2:0] code,
      input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    logic signed [65:0] xa, xi, ya, yi;
    logic [127:0] den;
    xa = ar; xi = ai; ya = br; yi = bi;
    r.re = 0; r.im = 0; r.ovf = 0; r.dz = 0;
    case (code)
      OP_ADD: begin
        r.re = clamp32((xa + ya) < 0, abs66(xa + ya), r.ovf);
        r.im = clamp32((xi + yi) < 0, abs66(xi + yi), r.ovf);
      end
      OP_MUL: begin
        r.re = fix_round(xa * ya - xi * yi, r.ovf);
        r.im = fix_round(xa * yi + xi * ya, r.ovf);
      end
      OP_DIV: begin
        den = 128'(ya * ya) + 128'(yi * yi);
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = fix_div(xa * ya + xi * yi, den, r.ovf);
          r.im = fix_div(xi * ya - xa * yi, den, r.ovf);
        end
      end
      OP_MAG1: r.re = root_mag(xa, xi, r.ovf);
      OP_MAG2: r.re = root_mag(ya, yi, r.ovf);
      OP_CONJ1: begin
        r.re = ar;
        r.im = clamp32(xi > 0, abs66(xi), r.ovf);
      end
      OP_CONJ2: begin
        r.re = br;
        r.im = clamp32(yi > 0, abs66(yi), r.ovf);
      end
      default: ;
    endcase
    return r;
  endfunction

  initial errors = 0;
  assign waiting = expected_results.size();

  // Queue predictions for accepted items, compare accepted results
  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_results.push_back(compute_result(op, first_real, first_imag,
                                                  second_real, second_imag));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%t unexpected result %h %h", $time, result_real, result_imag);
        end else begin
          e = expected_results.pop_front();
          if (result_real !== e.re) begin
            errors++;
            $display("%t result_real exp %h got %h", $time, e.re, result_real);
          end
          if (result_imag !== e.im) begin
            errors++;
            $display("%t result_imag exp %h got %h", $time, e.im, result_imag);
          end
          if (overflow !== e.ovf) begin
            errors++;
            $display("%t overflow exp %b got %b", $time, e.ovf, overflow);
          end
          if (divide_by_zero !== e.dz) begin
            errors++;
            $display("%t divide_by_zero exp %b got %b", $time, e.dz, divide_by_zero);
          end
        end
      end
    end
  end

endmodule

// ===== test/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
module complex_arithmetic_unit_test
  import cau_pkg::*;
();

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [31:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_Q = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [2:0] op = '0;
  logic signed [31:0] first_real = '0, first_imag = '0;
  logic signed [31:0] second_real = '0, second_imag = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, overflow, divide_by_zero;
  logic signed [31:0] result_real, result_imag;
  int errors, waiting;
  bit quiet_in = 0;
  bit quiet_out = 0;

  complex_arithmetic_unit u_top (.*);
  complex_arithmetic_unit_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Draw operand values biased toward extremes and small numbers
  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 6))
      0: return MAX_Q;
      1: return MIN_Q;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item after a random gap, hold it until taken
  task automatic send_item(input logic [2:0] o, input logic [31:0] a, b, c, d);
    int gap;
    if ($urandom_range(0, 40) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    first_real <= a;
    first_imag <= b;
    second_real <= c;
    second_imag <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stall the result side at random before taking each item
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 40) == 0) quiet_out = !quiet_out;
      n = quiet_out ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [2:0] o;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed corners
    send_item(OP_ADD, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_item(OP_MUL, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    send_item(OP_MUL, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    send_item(OP_MUL, 32'd1, 32'd0, 32'h8000, 32'd0);
    send_item(OP_MUL, 32'hFFFF_FFFF, 32'd0, 32'h8000, 32'd0);
    send_item(OP_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    send_item(OP_DIV, MAX_Q, MIN_Q, 32'd1, 32'd0);
    send_item(OP_DIV, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    send_item(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFE_0000);
    send_item(OP_DIV, 32'd1, 32'd0, 32'h0002_0000, 32'd0);
    send_item(OP_MAG1, MIN_Q, MIN_Q, 32'd0, 32'd0);
    send_item(OP_MAG1, 32'h0003_0000, 32'h0004_0000, MAX_Q, MAX_Q);
    send_item(OP_MAG2, 32'd0, 32'd0, MAX_Q, MIN_Q);
    send_item(OP_MAG2, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_MAG1, 32'd1, 32'd1, 32'd0, 32'd0);
    send_item(OP_CONJ1, MIN_Q, MIN_Q, 32'd5, 32'd6);
    send_item(OP_CONJ1, MAX_Q, MAX_Q, 32'd0, 32'd0);
    send_item(OP_CONJ2, 32'd1, 32'd2, MIN_Q, MIN_Q);
    send_item(OP_CONJ2, 32'd1, 32'd2, 32'd0, 32'd0);
    send_item(OP_UNUSED, MAX_Q, MIN_Q, 32'hFFFF_FFFF, 32'h1234_5678);

    // Random items
    repeat (900) begin
      o = 3'($urandom_range(0, 7));
      send_item(o, pick_val(), pick_val(), pick_val(), pick_val());
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_checker.sv
test/complex_arithmetic_unit_test.sv
